// ===== src/ptb_pkg.sv =====
// Shared constants, codes and link types for the periodic/one-shot timer bank.
// No dependencies; used by ptb_cell and periodic_oneshot_timer_bank.
package ptb_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 24;
    localparam int STEP_BITS = 16;

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int SUM_BITS  = ((TIME_BITS > STEP_BITS) ? TIME_BITS : STEP_BITS) + 1;
    localparam int HIDX_BITS = (SLOT_BITS > 4) ? SLOT_BITS : 4;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [2:0] KIND_STARTED = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_STOPPED = 3'd2;
    localparam logic [2:0] KIND_IDLE    = 3'd3;
    localparam logic [2:0] KIND_FIRED   = 3'd4;

    typedef logic [SLOT_BITS-1:0] slot_idx_t;

    // Tick token handed from one cell to the next, one cell per cycle.
    typedef struct packed {
        logic                 tok;
        logic [STEP_BITS-1:0] step;
    } ptb_link_t;

    // Per-cell command from the control logic.
    typedef struct packed {
        logic load;
        logic drop;
    } ptb_cmd_t;

endpackage

// ===== src/ptb_cell.sv =====
// One timer slot of the chain: active flag, one-shot mark, duration, elapsed count.
// Depends on ptb_pkg.
module ptb_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptb_pkg::ptb_cmd_t   cmd,
    input  logic                one_shot_in,
    input  logic [ptb_pkg::TIME_BITS-1:0] duration_in,
    input  ptb_pkg::ptb_link_t  link_in,
    output ptb_pkg::ptb_link_t  link_out,
    output logic                active,
    output logic                fire
);

    localparam logic [ptb_pkg::SUM_BITS-1:0] TIME_MAX =
        ptb_pkg::SUM_BITS'({ptb_pkg::TIME_BITS{1'b1}});

    logic                              active_reg;
    logic                              one_shot_reg;
    logic [ptb_pkg::TIME_BITS-1:0]     duration_reg;
    logic [ptb_pkg::TIME_BITS-1:0]     elapsed_reg;
    logic                              tok_reg;
    logic [ptb_pkg::STEP_BITS-1:0]     step_reg;
    logic [ptb_pkg::SUM_BITS-1:0]      sum;
    logic [ptb_pkg::TIME_BITS-1:0]     elapsed_next;

    // Saturating add of the step.
    assign sum = ptb_pkg::SUM_BITS'(elapsed_reg) + ptb_pkg::SUM_BITS'(link_in.step);
    assign elapsed_next = (sum > TIME_MAX) ? {ptb_pkg::TIME_BITS{1'b1}}
                                           : sum[ptb_pkg::TIME_BITS-1:0];

    assign fire     = link_in.tok && active_reg && (elapsed_next >= duration_reg);
    assign active   = active_reg;
    assign link_out = '{tok: tok_reg, step: step_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            tok_reg <= link_in.tok;
            if (cmd.load)
            begin
                active_reg <= 1'b1;
            end
            else if (cmd.drop)
            begin
                active_reg <= 1'b0;
            end
            else if (fire && one_shot_reg)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= link_in.step;
        if (cmd.load)
        begin
            one_shot_reg <= one_shot_in;
            duration_reg <= duration_in;
            elapsed_reg  <= '0;
        end
        else if (link_in.tok && active_reg)
        begin
            // restart a periodic slot that fired; a one-shot slot is freed anyway
            elapsed_reg <= fire ? '0 : elapsed_next;
        end
    end

endmodule

// ===== src/periodic_oneshot_timer_bank.sv =====
// Top level of the periodic/one-shot timer bank: command decode, chain of slot cells,
// result sequencing. Depends on ptb_pkg and ptb_cell.
//
// A bank of SLOTS timer slots, one cell per slot, chained in ascending slot order.
// Raise start with the item fields while busy is low; the item is taken at that edge.
// Start and stop items each yield a single result, which appears with valid high in
// the next cycle, with last set, and busy stays low, so a new item may follow at once.
// A tick item sends a token with the step down the chain, one cell per cycle, so busy
// stays high after the tick is taken until the token has left the last cell.
// Each slot that fires yields one fired result, in ascending slot order, one per cycle
// at most; the final one carries last. A tick where nothing fires yields no result.
// Results are shown for exactly one cycle with valid high and cannot be held off: the
// receiver must take every result in the cycle it is shown.
module periodic_oneshot_timer_bank (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic        one_shot,
    input  logic [23:0] duration,
    input  logic [15:0] time_step,
    input  logic [3:0]  handle,
    output logic        valid,
    output logic [2:0]  kind,
    output logic [3:0]  slot,
    output logic        last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic                      state_reg, state_next;
    logic                      valid_reg, valid_next;
    logic [2:0]                kind_reg, kind_next;
    logic [3:0]                slot_reg, slot_next;
    logic                      last_reg, last_next;
    logic                      pend_valid_reg, pend_valid_next;
    ptb_pkg::slot_idx_t        pend_idx_reg, pend_idx_next;

    logic                      accept;
    logic [ptb_pkg::SLOTS-1:0] active_vec;
    logic [ptb_pkg::SLOTS-1:0] fire_vec;
    ptb_pkg::ptb_cmd_t         cmd_vec [ptb_pkg::SLOTS];
    ptb_pkg::ptb_link_t        link [ptb_pkg::SLOTS+1];

    logic                      free_found;
    ptb_pkg::slot_idx_t        free_idx;
    logic [ptb_pkg::HIDX_BITS-1:0] handle_ext;
    ptb_pkg::slot_idx_t        stop_idx;
    logic                      handle_ok;
    logic                      stop_hit;
    logic                      any_fire;
    ptb_pkg::slot_idx_t        fire_idx;

    assign busy   = (state_reg == ST_TICK);
    assign accept = start && !busy;

    assign valid = valid_reg;
    assign kind  = kind_reg;
    assign slot  = slot_reg;
    assign last  = last_reg;

    // Lowest free slot for a start item.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ptb_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!active_vec[i])
            begin
                free_found = 1'b1;
                free_idx   = ptb_pkg::SLOT_BITS'(i);
            end
        end
    end

    // Handles at or beyond the bank size never hit.
    assign handle_ext = ptb_pkg::HIDX_BITS'(handle);
    assign stop_idx   = handle_ext[ptb_pkg::SLOT_BITS-1:0];
    assign handle_ok  = (32'(handle) < 32'(ptb_pkg::SLOTS));
    assign stop_hit   = handle_ok && active_vec[stop_idx];

    // The token visits one cell at a time, so at most one cell fires per cycle.
    always_comb
    begin
        fire_idx = '0;
        for (int i = 0; i < ptb_pkg::SLOTS; i++)
        begin
            if (fire_vec[i])
            begin
                fire_idx = fire_idx | ptb_pkg::SLOT_BITS'(i);
            end
        end
    end
    assign any_fire = |fire_vec;

    // Inject the tick token straight into the first cell on the accepting edge.
    assign link[0] = '{tok: accept && (action == ptb_pkg::ACT_TICK),
                       step: ptb_pkg::STEP_BITS'(time_step)};

    for (genvar g = 0; g < ptb_pkg::SLOTS; g++)
    begin : g_cell
        assign cmd_vec[g] = '{
            load: accept && (action == ptb_pkg::ACT_START) && free_found
                  && (free_idx == ptb_pkg::SLOT_BITS'(g)),
            drop: accept && (action == ptb_pkg::ACT_STOP) && stop_hit
                  && (stop_idx == ptb_pkg::SLOT_BITS'(g))
        };

        ptb_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd_vec[g]),
            .one_shot_in (one_shot),
            .duration_in (ptb_pkg::TIME_BITS'(duration)),
            .link_in     (link[g]),
            .link_out    (link[g+1]),
            .active      (active_vec[g]),
            .fire        (fire_vec[g])
        );
    end

    // Result sequencing. A fired slot waits in the pending register until the next
    // firing or the end of the chain tells whether it is the last result of the tick.
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = 1'b0;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;

        if (accept)
        begin
            unique case (action)
                ptb_pkg::ACT_START:
                begin
                    valid_next = 1'b1;
                    kind_next  = free_found ? ptb_pkg::KIND_STARTED : ptb_pkg::KIND_FULL;
                    slot_next  = free_found ? 4'(free_idx) : 4'd0;
                    last_next  = 1'b1;
                end
                ptb_pkg::ACT_STOP:
                begin
                    valid_next = 1'b1;
                    kind_next  = stop_hit ? ptb_pkg::KIND_STOPPED : ptb_pkg::KIND_IDLE;
                    slot_next  = handle;
                    last_next  = 1'b1;
                end
                ptb_pkg::ACT_TICK:
                begin
                    state_next = ST_TICK;
                end
                default:
                begin
                    // unused action code: drop the item
                end
            endcase
        end

        if (any_fire)
        begin
            if (pend_valid_reg)
            begin
                valid_next = 1'b1;
                kind_next  = ptb_pkg::KIND_FIRED;
                slot_next  = 4'(pend_idx_reg);
                last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_idx_next   = fire_idx;
        end

        // Token has left the last cell: flush the pending firing as the final result.
        if (link[ptb_pkg::SLOTS].tok)
        begin
            state_next = ST_IDLE;
            if (pend_valid_reg)
            begin
                valid_next = 1'b1;
                kind_next  = ptb_pkg::KIND_FIRED;
                slot_next  = 4'(pend_idx_reg);
                last_next  = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        slot_reg     <= slot_next;
        last_reg     <= last_next;
        pend_idx_reg <= pend_idx_next;
    end

endmodule
